// ===== hw/rtl/sdh_pkg.sv =====
package sdh_pkg;

  // request and byte codes on the input channel
  typedef enum logic [2:0] {
    CMD_INIT       = 3'd0,
    CMD_READ_ONE   = 3'd1,
    CMD_READ_MANY  = 3'd2,
    CMD_WRITE_ONE  = 3'd3,
    CMD_WRITE_MANY = 3'd4,
    CMD_CARD_BYTE  = 3'd5,
    CMD_WRITE_DATA = 3'd6,
    CMD_UNUSED     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SPI  = 2'd0,
    KIND_READ = 2'd1,
    KIND_NEED = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_BUSY = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_IDLE_RETRY  = 3'd0,
    CFG_READY_WAIT  = 3'd1,
    CFG_OP_RETRY    = 3'd2,
    CFG_TOKEN_WAIT  = 3'd3,
    CFG_MULTI_BUSY  = 3'd4
  } cfg_idx_t;

  localparam int unsigned CFG_W = 24;

  localparam logic [9:0]  BLOCK_BYTES       = 10'd512;
  localparam logic [23:0] R1_POLL_LIMIT     = 24'd10;
  localparam logic [9:0]  DUMMY_CLOCK_BYTES = 10'd15;
  localparam logic [23:0] DRESP_POLLS       = 24'd15;
  localparam logic [23:0] ERR_STOP_POLLS    = 24'd255;

  localparam logic [7:0] CRC_CMD0  = 8'h95;
  localparam logic [7:0] CRC_CMD8  = 8'h87;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] TOK_START = 8'hFE;
  localparam logic [7:0] TOK_MULTI = 8'hFC;
  localparam logic [7:0] TOK_STOP  = 8'hFD;
  localparam logic [31:0] ARG_HCS  = 32'h4000_0000;
  localparam logic [31:0] ARG_1AA  = 32'h0000_01AA;

  localparam logic [5:0] IDX_CMD0  = 6'd0;
  localparam logic [5:0] IDX_CMD1  = 6'd1;
  localparam logic [5:0] IDX_CMD8  = 6'd8;
  localparam logic [5:0] IDX_CMD12 = 6'd12;
  localparam logic [5:0] IDX_CMD16 = 6'd16;
  localparam logic [5:0] IDX_CMD17 = 6'd17;
  localparam logic [5:0] IDX_CMD18 = 6'd18;
  localparam logic [5:0] IDX_CMD24 = 6'd24;
  localparam logic [5:0] IDX_CMD25 = 6'd25;
  localparam logic [5:0] IDX_ACMD41 = 6'd41;
  localparam logic [5:0] IDX_CMD55 = 6'd55;
  localparam logic [5:0] IDX_CMD58 = 6'd58;

  typedef enum logic [19:0] {
    PH_IDLE      = 20'h00001,
    PH_DUMMY     = 20'h00002,
    PH_RDY_W     = 20'h00004,
    PH_RDY_POLL  = 20'h00008,
    PH_CMD_BYTES = 20'h00010,
    PH_R1        = 20'h00020,
    PH_OCR       = 20'h00040,
    PH_TOKEN     = 20'h00080,
    PH_RDATA     = 20'h00100,
    PH_RCRC      = 20'h00200,
    PH_BUSY0     = 20'h00400,
    PH_WSP       = 20'h00800,
    PH_WTOK      = 20'h01000,
    PH_NEED      = 20'h02000,
    PH_WDATA     = 20'h04000,
    PH_WCRC      = 20'h08000,
    PH_WRESP     = 20'h10000,
    PH_MRESP     = 20'h20000,
    PH_WFF       = 20'h40000,
    PH_STOPTOK   = 20'h80000
  } phase_t;

  typedef enum logic [3:0] {
    CT_CMD0       = 4'd0,
    CT_CMD8       = 4'd1,
    CT_V1_58      = 4'd2,
    CT_V1_41      = 4'd3,
    CT_V2_41      = 4'd4,
    CT_OPLOOP     = 4'd5,
    CT_V2_58      = 4'd6,
    CT_CMD16      = 4'd7,
    CT_CMD17      = 4'd8,
    CT_CMD18      = 4'd9,
    CT_STOP_READ  = 4'd10,
    CT_CMD24      = 4'd11,
    CT_CMD25      = 4'd12,
    CT_STOP_WRITE = 4'd13
  } cont_t;

  typedef enum logic [1:0] {
    WFF_SINGLE_OK = 2'd0,
    WFF_ERR       = 2'd1,
    WFF_MULTI     = 2'd2
  } wff_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] address;
    logic [7:0]  block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        chip_select_low;
    logic        fast_clock;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [2:0]  card_kind;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] idle_retry_limit;
    logic [23:0] ready_wait_limit;
    logic [15:0] op_cond_retry_limit;
    logic [15:0] token_wait_limit;
    logic [15:0] multi_busy_wait_limit;
  } cfg_t;

  // command frame byte k: start byte, four argument bytes msb first, crc
  function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
                                            input logic [31:0] arg);
    logic [7:0] b;
    case (k)
      3'd0:    b = {2'b01, idx};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (idx == IDX_CMD0) ? CRC_CMD0 : ((idx == IDX_CMD8) ? CRC_CMD8 : BYTE_FF);
    endcase
    return b;
  endfunction

  function automatic logic is_v2(input logic [2:0] ct);
    return (ct == 3'd2) || (ct == 3'd5);
  endfunction

endpackage

// ===== hw/rtl/sdh_outq.sv =====
module sdh_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  sdh_pkg::res_t push0,
  input  sdh_pkg::res_t push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_stall,
  output sdh_pkg::res_t out_res
);
  import sdh_pkg::*;

  res_t       mem_r [4];
  logic [1:0] head_r, tail_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_res   = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  // two free slots needed for the worst case of one transaction
  assign room      = (cnt_r <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[tail_r] <= push0;
    if (push_n == 2'd2) mem_r[2'(tail_r + 2'd1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_r + {1'b0, pop};
      tail_r <= tail_r + push_n;
      cnt_r  <= 3'(cnt_r + {1'b0, push_n} - {2'b00, pop});
    end
  end

endmodule

// ===== hw/rtl/sdh_ctrl.sv =====
module sdh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  sdh_pkg::item_t item,
  input  sdh_pkg::cfg_t  cfg,
  output logic [1:0]     res_n,
  output sdh_pkg::res_t  res0,
  output sdh_pkg::res_t  res1
);
  import sdh_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  ct_r, ct_nxt;
  logic [23:0] wait_r, wait_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [7:0]  bl_r, bl_nxt;
  logic [31:0] baddr_r, baddr_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [31:0] ocr_r, ocr_nxt;
  logic        mmc_r, mmc_nxt;
  logic        fast_r, fast_nxt;
  logic [2:0]  req_r, req_nxt;
  cont_t       cont_r, cont_nxt;
  logic        pfx_r, pfx_nxt;
  logic        rdyf_r, rdyf_nxt;
  wff_t        wff_r, wff_nxt;
  logic [31:0] sarg_r, sarg_nxt;
  logic [15:0] retry_r, retry_nxt;

  logic        snd_go, fin_go, dum_go, need_go, rd_go;
  logic [7:0]  snd_byte, rd_byte, rx, ob1, ob2, ob3;
  phase_t      snd_ph;
  status_t     fin_st;
  logic        cr_go, ocr_go, sc_go, sc_acmd, op_go, bf_go, rocr_go, tw_go;
  logic [7:0]  cr_val;
  logic [5:0]  sc_idx;
  logic [31:0] sc_arg, addr;
  cont_t       sc_cont;
  logic        poll;
  res_t        prim;

  assign rx   = item.rx_byte;
  assign poll = (wait_r > 24'd1);

  always_comb begin
    phase_nxt = phase_r; ct_nxt = ct_r; wait_nxt = wait_r; bc_nxt = bc_r; bl_nxt = bl_r;
    baddr_nxt = baddr_r; pend_nxt = pend_r; arg_nxt = arg_r; ocr_nxt = ocr_r;
    mmc_nxt = mmc_r; fast_nxt = fast_r; req_nxt = req_r; cont_nxt = cont_r;
    pfx_nxt = pfx_r; rdyf_nxt = rdyf_r; wff_nxt = wff_r; sarg_nxt = sarg_r;
    retry_nxt = retry_r;
    snd_go = 1'b0; snd_byte = BYTE_FF; snd_ph = PH_IDLE;
    fin_go = 1'b0; fin_st = ST_OK; dum_go = 1'b0; need_go = 1'b0;
    rd_go = 1'b0; rd_byte = '0;
    cr_go = 1'b0; cr_val = '0; ocr_go = 1'b0;
    sc_go = 1'b0; sc_acmd = 1'b0; sc_idx = '0; sc_arg = '0; sc_cont = CT_CMD0;
    op_go = 1'b0; bf_go = 1'b0; rocr_go = 1'b0; tw_go = 1'b0;
    addr = item.address;
    ob1 = '0; ob2 = '0; ob3 = '0;

    // event decode
    if (step_en) begin
      case (item.cmd)
        CMD_INIT, CMD_READ_ONE, CMD_READ_MANY, CMD_WRITE_ONE, CMD_WRITE_MANY: begin
          if (phase_r == PH_IDLE) begin
            req_nxt = item.cmd;
            if (item.cmd == CMD_INIT) begin
              fast_nxt  = 1'b0;
              retry_nxt = cfg.idle_retry_limit;
              bc_nxt    = '0;
              dum_go    = 1'b1;
              phase_nxt = PH_DUMMY;
            end else begin
              if (ct_r == 3'd3 || ct_r == 3'd6) addr = {9'd0, item.address[31:9]};
              baddr_nxt = addr;
              bl_nxt    = item.block_count;
              sc_go     = 1'b1;
              sc_arg    = addr;
              case (item.cmd)
                CMD_READ_ONE:  begin sc_idx = IDX_CMD17; sc_cont = CT_CMD17; end
                CMD_READ_MANY: begin sc_idx = IDX_CMD18; sc_cont = CT_CMD18; end
                CMD_WRITE_ONE: begin sc_idx = IDX_CMD24; sc_cont = CT_CMD24; end
                default:       begin sc_idx = IDX_CMD25; sc_cont = CT_CMD25; end
              endcase
            end
          end
        end
        CMD_CARD_BYTE: begin
          unique case (phase_r)
            PH_DUMMY: begin
              bc_nxt = bc_r + 10'd1;
              if (bc_nxt < DUMMY_CLOCK_BYTES) dum_go = 1'b1;
              else begin sc_go = 1'b1; sc_idx = IDX_CMD0; sc_cont = CT_CMD0; end
            end
            PH_RDY_W: begin snd_go = 1'b1; snd_ph = PH_RDY_POLL; end
            PH_RDY_POLL: begin
              if (rx == BYTE_FF) begin
                if (rdyf_r) begin snd_go = 1'b1; snd_byte = TOK_MULTI; snd_ph = PH_WTOK; end
                else begin
                  bc_nxt = '0; snd_go = 1'b1; snd_ph = PH_CMD_BYTES;
                  snd_byte = frame_byte(3'd0, pend_r, arg_r);
                end
              end else if (poll) begin
                wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_RDY_POLL;
              end else if (rdyf_r) begin fin_go = 1'b1; fin_st = ST_BUSY; end
              else begin cr_go = 1'b1; cr_val = BYTE_FF; end
            end
            PH_CMD_BYTES: begin
              bc_nxt = bc_r + 10'd1;
              snd_go = 1'b1;
              if (bc_nxt < 10'd6) begin
                snd_ph = PH_CMD_BYTES; snd_byte = frame_byte(bc_nxt[2:0], pend_r, arg_r);
              end else begin wait_nxt = R1_POLL_LIMIT; snd_ph = PH_R1; end
            end
            PH_R1: begin
              if (rx[7] && poll) begin
                wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_R1;
              end else begin cr_go = 1'b1; cr_val = rx; end
            end
            PH_OCR: begin
              ocr_nxt = {ocr_r[23:0], rx};
              bc_nxt  = bc_r + 10'd1;
              if (bc_nxt < 10'd4) begin snd_go = 1'b1; snd_ph = PH_OCR; end
              else ocr_go = 1'b1;
            end
            PH_TOKEN: begin
              if (rx == TOK_START) begin bc_nxt = '0; snd_go = 1'b1; snd_ph = PH_RDATA; end
              else if (poll) begin wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_TOKEN; end
              else begin fin_go = 1'b1; fin_st = ST_FAIL; end
            end
            PH_RDATA: begin
              rd_go = 1'b1; rd_byte = rx;
              bc_nxt = bc_r + 10'd1;
              snd_go = 1'b1; snd_ph = PH_RDATA;
              if (bc_r == BLOCK_BYTES - 10'd1) begin bc_nxt = '0; snd_ph = PH_RCRC; end
            end
            PH_RCRC: begin
              bc_nxt = bc_r + 10'd1;
              if (bc_nxt < 10'd2) begin snd_go = 1'b1; snd_ph = PH_RCRC; end
              else if (req_r == CMD_READ_ONE) begin fin_go = 1'b1; fin_st = ST_OK; end
              else begin
                bl_nxt = bl_r - 8'd1;
                if (bl_nxt != 8'd0) tw_go = 1'b1;
                else begin sc_go = 1'b1; sc_idx = IDX_CMD12; sc_cont = CT_STOP_READ; end
              end
            end
            PH_BUSY0: begin
              if (rx != 8'd0) begin fin_go = 1'b1; fin_st = ST_OK; end
              else if (poll) begin wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_BUSY0; end
              else begin fin_go = 1'b1; fin_st = ST_BUSY; end
            end
            PH_WSP: begin
              snd_go = 1'b1;
              if (req_r == CMD_WRITE_ONE) begin snd_byte = TOK_START; snd_ph = PH_WTOK; end
              else begin rdyf_nxt = 1'b1; wait_nxt = cfg.ready_wait_limit; snd_ph = PH_RDY_W; end
            end
            PH_WTOK: begin bc_nxt = '0; need_go = 1'b1; phase_nxt = PH_NEED; end
            PH_WDATA: begin
              bc_nxt = bc_r + 10'd1;
              if (bc_nxt < BLOCK_BYTES) begin need_go = 1'b1; phase_nxt = PH_NEED; end
              else if (req_r == CMD_WRITE_ONE) begin
                bc_nxt = '0; snd_go = 1'b1; snd_ph = PH_WCRC;
              end else begin wait_nxt = DRESP_POLLS; snd_go = 1'b1; snd_ph = PH_MRESP; end
            end
            PH_WCRC: begin
              bc_nxt = bc_r + 10'd1;
              snd_go = 1'b1;
              snd_ph = (bc_nxt < 10'd2) ? PH_WCRC : PH_WRESP;
            end
            PH_WRESP: begin
              if (rx[4:0] != 5'h05) begin
                sc_go = 1'b1; sc_idx = IDX_CMD12; sc_cont = CT_STOP_WRITE;
              end else begin
                wait_nxt = {8'd0, cfg.token_wait_limit}; wff_nxt = WFF_SINGLE_OK;
                snd_go = 1'b1; snd_ph = PH_WFF;
              end
            end
            PH_MRESP: begin
              if (rx[4:0] == 5'h05) begin
                wait_nxt = {8'd0, cfg.multi_busy_wait_limit}; wff_nxt = WFF_MULTI;
                snd_go = 1'b1; snd_ph = PH_WFF;
              end else if (poll) begin
                wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_MRESP;
              end else begin sc_go = 1'b1; sc_idx = IDX_CMD12; sc_cont = CT_STOP_WRITE; end
            end
            PH_WFF: begin
              if (rx != BYTE_FF && poll) begin
                wait_nxt = wait_r - 24'd1; snd_go = 1'b1; snd_ph = PH_WFF;
              end else if (wff_r == WFF_SINGLE_OK) begin fin_go = 1'b1; fin_st = ST_OK; end
              else if (wff_r == WFF_ERR) begin
                fin_go = 1'b1; fin_st = (rx == BYTE_FF) ? ST_FAIL : ST_BUSY;
              end else begin
                bl_nxt = bl_r - 8'd1;
                snd_go = 1'b1;
                if (bl_nxt != 8'd0) snd_ph = PH_WSP;
                else begin snd_byte = TOK_STOP; snd_ph = PH_STOPTOK; end
              end
            end
            PH_STOPTOK: begin fin_go = 1'b1; fin_st = ST_OK; end
            PH_IDLE, PH_NEED: ;
            default: ;
          endcase
        end
        CMD_WRITE_DATA: begin
          if (phase_r == PH_NEED) begin
            snd_go = 1'b1; snd_byte = item.write_byte; snd_ph = PH_WDATA;
          end
        end
        default: ;
      endcase
    end

    // ocr collected
    if (ocr_go) begin
      ob1 = ocr_nxt[23:16]; ob2 = ocr_nxt[15:8]; ob3 = ocr_nxt[7:0];
      if (cont_r == CT_CMD8) begin
        if (ob2 != 8'h01 || ob3 != 8'hAA) begin fin_go = 1'b1; fin_st = ST_FAIL; end
        else begin
          sc_go = 1'b1; sc_idx = IDX_ACMD41; sc_arg = ARG_HCS; sc_acmd = 1'b1; sc_cont = CT_V2_41;
        end
      end else if (cont_r == CT_V1_58) begin
        if (ob1[4:0] != 5'd0 && ob2 != 8'd0 && ob3 != 8'd0) begin
          ct_nxt = 3'd7; fin_go = 1'b1; fin_st = ST_FAIL;
        end else begin
          sc_go = 1'b1; sc_idx = IDX_ACMD41; sc_acmd = 1'b1; sc_cont = CT_V1_41;
        end
      end else begin
        if (ocr_nxt[30]) ct_nxt = ct_r + 3'd1;
        sc_go = 1'b1; sc_idx = IDX_CMD16; sc_arg = {22'd0, BLOCK_BYTES}; sc_cont = CT_CMD16;
      end
    end

    // command response
    if (cr_go) begin
      if (pfx_r && cr_val <= 8'd1) begin
        pfx_nxt = 1'b0; pend_nxt = IDX_ACMD41; arg_nxt = sarg_r; bf_go = 1'b1;
      end else begin
        pfx_nxt = 1'b0;
        unique case (cont_r)
          CT_CMD0: begin
            if (cr_val == 8'd1) begin
              sc_go = 1'b1; sc_idx = IDX_CMD8; sc_arg = ARG_1AA; sc_cont = CT_CMD8;
            end else if (retry_r <= 16'd1) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else begin
              retry_nxt = retry_r - 16'd1; bc_nxt = '0; dum_go = 1'b1; phase_nxt = PH_DUMMY;
            end
          end
          CT_CMD8: begin
            if (cr_val[2]) begin sc_go = 1'b1; sc_idx = IDX_CMD58; sc_cont = CT_V1_58; end
            else if (cr_val == 8'd1) rocr_go = 1'b1;
            else begin fin_go = 1'b1; fin_st = ST_FAIL; end
          end
          CT_V1_58: begin
            if (cr_val == 8'd1) rocr_go = 1'b1;
            else begin fin_go = 1'b1; fin_st = ST_FAIL; end
          end
          CT_V1_41, CT_V2_41: begin
            if (cr_val[2]) begin
              mmc_nxt = 1'b1; ct_nxt = (cont_r == CT_V1_41) ? 3'd4 : 3'd5;
              retry_nxt = cfg.op_cond_retry_limit; op_go = 1'b1;
            end else if (cr_val <= 8'd1) begin
              mmc_nxt = 1'b0; ct_nxt = (cont_r == CT_V1_41) ? 3'd1 : 3'd2;
              retry_nxt = cfg.op_cond_retry_limit; op_go = 1'b1;
            end else begin fin_go = 1'b1; fin_st = ST_FAIL; end
          end
          CT_OPLOOP: begin
            if (cr_val == 8'd0) begin
              sc_go = 1'b1;
              if (is_v2(ct_r)) begin sc_idx = IDX_CMD58; sc_cont = CT_V2_58; end
              else begin sc_idx = IDX_CMD16; sc_arg = {22'd0, BLOCK_BYTES}; sc_cont = CT_CMD16; end
            end else if (retry_r <= 16'd1) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else begin retry_nxt = retry_r - 16'd1; op_go = 1'b1; end
          end
          CT_V2_58: begin
            if (cr_val <= 8'd1) rocr_go = 1'b1;
            else begin fin_go = 1'b1; fin_st = ST_FAIL; end
          end
          CT_CMD16: begin
            fin_go = 1'b1;
            if (cr_val != 8'd0) fin_st = ST_FAIL;
            else begin fast_nxt = 1'b1; fin_st = ST_OK; end
          end
          CT_CMD17: begin
            if (cr_val != 8'd0) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else tw_go = 1'b1;
          end
          CT_CMD18: begin
            if (cr_val != 8'd0) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else if (bl_r == 8'd0) begin
              sc_go = 1'b1; sc_idx = IDX_CMD12; sc_cont = CT_STOP_READ;
            end else tw_go = 1'b1;
          end
          CT_STOP_READ: begin
            wait_nxt = {8'd0, cfg.token_wait_limit}; snd_go = 1'b1; snd_ph = PH_BUSY0;
          end
          CT_CMD24: begin
            if (cr_val != 8'd0) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else begin snd_go = 1'b1; snd_ph = PH_WSP; end
          end
          CT_CMD25: begin
            if (cr_val != 8'd0) begin fin_go = 1'b1; fin_st = ST_FAIL; end
            else if (bl_r == 8'd0) begin snd_go = 1'b1; snd_byte = TOK_STOP; snd_ph = PH_STOPTOK; end
            else begin snd_go = 1'b1; snd_ph = PH_WSP; end
          end
          default: begin
            wait_nxt = (req_r == CMD_WRITE_ONE) ? {8'd0, cfg.token_wait_limit} : ERR_STOP_POLLS;
            wff_nxt = WFF_ERR; snd_go = 1'b1; snd_ph = PH_WFF;
          end
        endcase
      end
    end

    // operating-condition command, acmd41 or cmd1
    if (op_go) begin
      sc_go   = 1'b1;
      sc_arg  = is_v2(ct_nxt) ? ARG_HCS : 32'd0;
      sc_idx  = mmc_nxt ? IDX_CMD1 : IDX_ACMD41;
      sc_acmd = !mmc_nxt;
      sc_cont = CT_OPLOOP;
    end

    if (sc_go) begin
      cont_nxt = sc_cont;
      if (sc_acmd) begin
        pfx_nxt = 1'b1; sarg_nxt = sc_arg; pend_nxt = IDX_CMD55; arg_nxt = '0;
      end else begin
        pfx_nxt = 1'b0; pend_nxt = sc_idx; arg_nxt = sc_arg;
      end
      bf_go = 1'b1;
    end

    if (bf_go) begin
      rdyf_nxt = 1'b0; wait_nxt = cfg.ready_wait_limit; snd_go = 1'b1; snd_ph = PH_RDY_W;
    end
    if (rocr_go) begin
      bc_nxt = '0; ocr_nxt = '0; snd_go = 1'b1; snd_ph = PH_OCR;
    end
    if (tw_go) begin
      wait_nxt = {8'd0, cfg.token_wait_limit}; snd_go = 1'b1; snd_ph = PH_TOKEN;
    end

    if (snd_go) phase_nxt = snd_ph;
    if (fin_go) phase_nxt = PH_IDLE;

    // result assembly
    prim = '0;
    prim.fast_clock = fast_nxt;
    prim.card_kind  = ct_nxt;
    prim.last       = 1'b1;
    if (snd_go) begin
      prim.kind = KIND_SPI; prim.tx_byte = snd_byte; prim.chip_select_low = 1'b1;
    end else if (fin_go) begin
      prim.kind = KIND_DONE; prim.status = fin_st;
    end else if (dum_go) begin
      prim.kind = KIND_SPI; prim.tx_byte = BYTE_FF;
    end else begin
      prim.kind = KIND_NEED; prim.chip_select_low = 1'b1;
    end

    res1 = prim;
    res0 = prim;
    res_n = (snd_go || fin_go || dum_go || need_go) ? 2'd1 : 2'd0;
    if (rd_go) begin
      res0 = '0;
      res0.kind = KIND_READ;
      res0.chip_select_low = 1'b1;
      res0.fast_clock = fast_nxt;
      res0.read_byte = rd_byte;
      res0.card_kind = ct_nxt;
      res_n = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; ct_r <= '0; wait_r <= '0; bc_r <= '0; bl_r <= '0;
      baddr_r <= '0; pend_r <= '0; arg_r <= '0; ocr_r <= '0; mmc_r <= 1'b0;
      fast_r <= 1'b0; req_r <= '0; cont_r <= CT_CMD0; pfx_r <= 1'b0; rdyf_r <= 1'b0;
      wff_r <= WFF_SINGLE_OK; sarg_r <= '0; retry_r <= '0;
    end else begin
      phase_r <= phase_nxt; ct_r <= ct_nxt; wait_r <= wait_nxt; bc_r <= bc_nxt;
      bl_r <= bl_nxt; baddr_r <= baddr_nxt; pend_r <= pend_nxt; arg_r <= arg_nxt;
      ocr_r <= ocr_nxt; mmc_r <= mmc_nxt; fast_r <= fast_nxt; req_r <= req_nxt;
      cont_r <= cont_nxt; pfx_r <= pfx_nxt; rdyf_r <= rdyf_nxt; wff_r <= wff_nxt;
      sarg_r <= sarg_nxt; retry_r <= retry_nxt;
    end
  end

endmodule

// ===== hw/rtl/sd_card_spi_host_engine_core.sv =====
// path: accepted transactions are held in the input register, results in the result queue
// throughput: one input transaction per cycle while the result queue has room; a read data
//   byte brings two results, and the queue sends one per cycle while out_stall is low
// reset: synchronous, active low; clears the sequencer state, card type, speed flag and the
//   result queue and loads the default wait and retry limits
module sd_card_spi_host_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_address,
  input  logic [7:0]  in_block_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select_low,
  output logic        out_fast_clock,
  output logic [7:0]  out_read_byte,
  output logic [1:0]  out_status,
  output logic [2:0]  out_card_kind,
  output logic        out_last
);
  import sdh_pkg::*;

  cfg_t       cfg_r;
  item_t      item_r;
  logic       item_v_r;
  logic       room, step_en;
  logic [1:0] res_n;
  res_t       res0, res1, out_res;

  // limit registers; the user must write them only while the engine is idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_retry_limit      <= 16'd4095;
      cfg_r.ready_wait_limit      <= 24'd1488492;
      cfg_r.op_cond_retry_limit   <= 16'd65535;
      cfg_r.token_wait_limit      <= 16'd4095;
      cfg_r.multi_busy_wait_limit <= 16'd65535;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDLE_RETRY: cfg_r.idle_retry_limit      <= cfg_data[15:0];
        CFG_READY_WAIT: cfg_r.ready_wait_limit      <= cfg_data;
        CFG_OP_RETRY:   cfg_r.op_cond_retry_limit   <= cfg_data[15:0];
        CFG_TOKEN_WAIT: cfg_r.token_wait_limit      <= cfg_data[15:0];
        CFG_MULTI_BUSY: cfg_r.multi_busy_wait_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register; the held transaction steps the sequencer once the
  // result queue has room for two results
  assign step_en  = item_v_r && room;
  assign in_stall = item_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_v_r <= 1'b1;
    end else if (step_en) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.cmd         <= in_cmd;
      item_r.address     <= in_address;
      item_r.block_count <= in_block_count;
      item_r.rx_byte     <= in_rx_byte;
      item_r.write_byte  <= in_write_byte;
    end
  end

  // protocol sequencer: init, command framing, data phases
  sdh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (item_r),
    .cfg     (cfg_r),
    .res_n   (res_n),
    .res0    (res0),
    .res1    (res1)
  );

  // result queue, decouples the result side from the sequencer
  sdh_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind            = out_res.kind;
  assign out_tx_byte         = out_res.tx_byte;
  assign out_chip_select_low = out_res.chip_select_low;
  assign out_fast_clock      = out_res.fast_clock;
  assign out_read_byte       = out_res.read_byte;
  assign out_status          = out_res.status;
  assign out_card_kind       = out_res.card_kind;
  assign out_last            = out_res.last;

endmodule
